// ===== hw/rtl/plgs_pkg.sv =====
// ----------------------------------------------------------------------------
// plgs_pkg
// Shared types and constants for the lookahead goal selector.
// ----------------------------------------------------------------------------
`default_nettype none
package plgs_pkg;

  localparam int PATH_DEPTH  = 1024;
  localparam int COORD_W     = 24;
  localparam int ADDR_W      = $clog2(PATH_DEPTH);
  localparam int COUNT_W     = ADDR_W + 1;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int DIST_W      = 2 * COORD_W + 1;
  localparam int POINT_W     = 2 * COORD_W;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [CFG_IDX_W-1:0] REG_RADIUS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BAND      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 2'd2;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_POS  = 1'b1;

  localparam logic KIND_GOAL   = 1'b0;
  localparam logic KIND_ARRIVE = 1'b1;

  typedef struct packed {
    logic                      pos;
    logic                      fin;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

endpackage
`default_nettype wire

// ===== hw/rtl/path_lookahead_goal_select_core.sv =====
// ----------------------------------------------------------------------------
// path_lookahead_goal_select_core
// Lookahead goal selector on a double-banked stored path.
// ----------------------------------------------------------------------------
// Path point beats retire one per cycle when the engine is idle; no result.
// Position beat: result strobe after the S_DSUB, S_DSQ and S_EVAL states.
// Goal query (final point, same count): a nearest pass over the N points, then
// a forward scan from it, all reads through the single read port of the store.
// busy stays high while the four-beat queue is full; results cannot be stalled.
// Synchronous reset clears control state; no clearing pass over memory.
// ----------------------------------------------------------------------------
`default_nettype none
module path_lookahead_goal_select_core (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic                                 action,
  input  wire logic signed [plgs_pkg::COORD_W-1:0]  coord_x,
  input  wire logic signed [plgs_pkg::COORD_W-1:0]  coord_y,
  input  wire logic                                 final_point,
  input  wire logic                                 cfg_we,
  input  wire logic [plgs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [plgs_pkg::CFG_W-1:0]           cfg_data,
  output logic                                      done,
  output logic                                      kind,
  output logic signed [plgs_pkg::COORD_W-1:0]       goal_x,
  output logic signed [plgs_pkg::COORD_W-1:0]       goal_y,
  output logic                                      arrived,
  output logic                                      overflow
);
  import plgs_pkg::*;

  queue_head_t head;
  logic        pop;

  plgs_front u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .action      (action),
    .coord_x     (coord_x),
    .coord_y     (coord_y),
    .final_point (final_point),
    .pop         (pop),
    .busy        (busy),
    .head        (head)
  );

  plgs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .head      (head),
    .pop       (pop),
    .done      (done),
    .kind      (kind),
    .goal_x    (goal_x),
    .goal_y    (goal_y),
    .arrived   (arrived),
    .overflow  (overflow)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/plgs_ram.sv =====
// ----------------------------------------------------------------------------
// plgs_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module plgs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/plgs_front.sv =====
// ----------------------------------------------------------------------------
// plgs_front
// Accept and tag input beats and hold them in a short queue for the engine.
// ----------------------------------------------------------------------------
`default_nettype none
module plgs_front (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  input  wire logic                               action,
  input  wire logic signed [plgs_pkg::COORD_W-1:0] coord_x,
  input  wire logic signed [plgs_pkg::COORD_W-1:0] coord_y,
  input  wire logic                               final_point,
  input  wire logic                               pop,
  output logic                                    busy,
  output plgs_pkg::queue_head_t                   head
);
  import plgs_pkg::*;

  item_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wp;
  logic [QPTR_W-1:0] rp;
  logic [QPTR_W:0]   cnt;
  logic              push;
  item_t             tagged_item;

  always_comb begin
    busy             = (cnt == (QPTR_W+1)'(QUEUE_DEPTH));
    push             = start && !busy;
    tagged_item.pos  = (action == ACT_POS);
    tagged_item.fin  = final_point && (action == ACT_LOAD);
    tagged_item.x    = coord_x;
    tagged_item.y    = coord_y;
    head.valid       = (cnt != '0);
    head.item        = slots[rp];
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= tagged_item;
    end
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= wp + 1'b1;
      end
      if (pop) begin
        rp <= rp + 1'b1;
      end
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) pop |-> head.valid)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (rst) busy |=> !$past(push))
    else $error("push while full");
  assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> cnt == $past(cnt) + 1'b1)
    else $error("queue count lost a beat");

endmodule
`default_nettype wire

// ===== hw/rtl/plgs_back.sv =====
// ----------------------------------------------------------------------------
// plgs_back
// Execute queued beats: path loads, bank swaps, goal queries, arrival checks.
// ----------------------------------------------------------------------------
`default_nettype none
module plgs_back (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_we,
  input  wire logic [plgs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [plgs_pkg::CFG_W-1:0]           cfg_data,
  input  wire plgs_pkg::queue_head_t                head,
  output logic                                      pop,
  output logic                                      done,
  output logic                                      kind,
  output logic signed [plgs_pkg::COORD_W-1:0]       goal_x,
  output logic signed [plgs_pkg::COORD_W-1:0]       goal_y,
  output logic                                      arrived,
  output logic                                      overflow
);
  import plgs_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_LAT  = 3'd2;
  localparam logic [2:0] S_DSUB = 3'd3;
  localparam logic [2:0] S_DSQ  = 3'd4;
  localparam logic [2:0] S_EVAL = 3'd5;

  localparam logic [2:0] PH_NEAR  = 3'd0;
  localparam logic [2:0] PH_NLOAD = 3'd1;
  localparam logic [2:0] PH_SCAN  = 3'd2;
  localparam logic [2:0] PH_PLOAD = 3'd3;
  localparam logic [2:0] PH_SNAP  = 3'd4;
  localparam logic [2:0] PH_ARR   = 3'd5;

  logic [2:0]                state;
  logic [2:0]                phase;
  logic                      bank;
  logic [COUNT_W-1:0]        active_count;
  logic [COUNT_W-1:0]        load_count;
  logic                      load_over;
  logic                      over_flag;
  logic [ADDR_W-1:0]         last_pick;
  logic [ADDR_W-1:0]         vis_lim;
  logic [ADDR_W-1:0]         idx;
  logic [ADDR_W-1:0]         near;
  logic [DIST_W-1:0]         best;
  logic signed [COORD_W-1:0] robot_x, robot_y;
  logic signed [COORD_W-1:0] cur_x, cur_y;
  logic signed [COORD_W-1:0] near_x, near_y;
  logic [COORD_W-1:0]        dxa, dya;
  logic [2*COORD_W-1:0]      sqx, sqy;
  logic [CFG_W-1:0]          radius, band, tol;
  logic [2*CFG_W-1:0]        r2, t2;
  logic [2*CFG_W+1:0]        hi2;

  logic                      ram_we, ram_re;
  logic [ADDR_W:0]           ram_waddr, ram_raddr;
  logic [POINT_W-1:0]        ram_rdata;
  logic signed [COORD_W-1:0] rd_x, rd_y;
  logic signed [COORD_W-1:0] a_x, a_y, b_x, b_y;
  logic signed [COORD_W:0]   diff_x, diff_y;
  logic [DIST_W-1:0]         dsum;
  logic [ADDR_W-1:0]         last;
  logic                      wr_ok;
  logic [COUNT_W-1:0]        cnt_new;
  logic                      hit;
  logic [ADDR_W-1:0]         cand;
  logic [ADDR_W-1:0]         pk;
  logic                      near_upd;
  logic                      snap;

  plgs_ram #(.WIDTH(POINT_W), .DEPTH(2 * PATH_DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({head.item.x, head.item.y}),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    pop       = (state == S_IDLE) && head.valid;
    wr_ok     = (load_count < COUNT_W'(PATH_DEPTH));
    cnt_new   = load_count + COUNT_W'(wr_ok);
    ram_we    = pop && !head.item.pos && wr_ok;
    ram_waddr = {~bank, load_count[ADDR_W-1:0]};
    ram_re    = (state == S_RD);
    ram_raddr = {bank, idx};
    rd_x      = ram_rdata[POINT_W-1:COORD_W];
    rd_y      = ram_rdata[COORD_W-1:0];
    last      = ADDR_W'(active_count - 1'b1);
    a_x       = (phase == PH_ARR) ? robot_x : rd_x;
    a_y       = (phase == PH_ARR) ? robot_y : rd_y;
    unique case (phase)
      PH_NEAR: begin
        b_x = robot_x;
        b_y = robot_y;
      end
      PH_SCAN: begin
        b_x = near_x;
        b_y = near_y;
      end
      default: begin
        b_x = cur_x;
        b_y = cur_y;
      end
    endcase
    diff_x   = {a_x[COORD_W-1], a_x} - {b_x[COORD_W-1], b_x};
    diff_y   = {a_y[COORD_W-1], a_y} - {b_y[COORD_W-1], b_y};
    dsum     = DIST_W'(sqx) + DIST_W'(sqy);
    near_upd = (idx == '0) || (dsum < best);
    hit      = (dsum >= DIST_W'(r2)) && (dsum < DIST_W'(hi2)) && (idx >= vis_lim);
    cand     = (state == S_EVAL && hit) ? idx : last_pick;
    pk       = (cand > last) ? last : cand;
    snap     = (dsum <= DIST_W'(hi2));
  end

  always_ff @(posedge clk) begin
    r2  <= radius * radius;
    hi2 <= ({1'b0, radius} + {1'b0, band}) * ({1'b0, radius} + {1'b0, band});
    t2  <= tol * tol;
    dxa <= diff_x[COORD_W] ? COORD_W'(-diff_x) : COORD_W'(diff_x);
    dya <= diff_y[COORD_W] ? COORD_W'(-diff_y) : COORD_W'(diff_y);
    sqx <= dxa * dxa;
    sqy <= dya * dya;
    if (rst) begin
      state        <= S_IDLE;
      phase        <= PH_NEAR;
      bank         <= 1'b0;
      active_count <= '0;
      load_count   <= '0;
      load_over    <= 1'b0;
      over_flag    <= 1'b0;
      last_pick    <= '0;
      vis_lim      <= '0;
      idx          <= '0;
      near         <= '0;
      robot_x      <= '0;
      robot_y      <= '0;
      cur_x        <= '0;
      cur_y        <= '0;
      radius       <= CFG_W'(256);
      band         <= CFG_W'(77);
      tol          <= CFG_W'(26);
      done         <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_RADIUS:    radius <= cfg_data;
          REG_BAND:      band   <= cfg_data;
          REG_TOLERANCE: tol    <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            if (head.item.pos) begin
              robot_x <= head.item.x;
              robot_y <= head.item.y;
              phase   <= PH_ARR;
              state   <= S_DSUB;
            end else if (head.item.fin) begin
              over_flag  <= load_over | ~wr_ok;
              load_over  <= 1'b0;
              load_count <= '0;
              if (cnt_new != active_count) begin
                bank         <= ~bank;
                active_count <= cnt_new;
                vis_lim      <= '0;
                last_pick    <= '0;
              end else begin
                phase <= PH_NEAR;
                idx   <= '0;
                state <= S_RD;
              end
            end else begin
              load_count <= cnt_new;
              load_over  <= load_over | ~wr_ok;
            end
          end
        end
        S_RD: begin
          state <= (phase == PH_NLOAD || phase == PH_PLOAD) ? S_LAT : S_DSUB;
        end
        S_LAT: begin
          if (phase == PH_NLOAD) begin
            near_x <= rd_x;
            near_y <= rd_y;
            if (idx == last) begin
              last_pick <= pk;
              if (pk > vis_lim) vis_lim <= pk;
              idx   <= pk;
              phase <= PH_PLOAD;
            end else begin
              idx   <= idx + 1'b1;
              phase <= PH_SCAN;
            end
          end else begin
            cur_x <= rd_x;
            cur_y <= rd_y;
            idx   <= last;
            phase <= PH_SNAP;
          end
          state <= S_RD;
        end
        S_DSUB: state <= S_DSQ;
        S_DSQ:  state <= S_EVAL;
        S_EVAL: begin
          unique case (phase)
            PH_NEAR: begin
              if (near_upd) begin
                best <= dsum;
                near <= idx;
              end
              if (idx == last) begin
                idx   <= near_upd ? idx : near;
                phase <= PH_NLOAD;
              end else begin
                idx <= idx + 1'b1;
              end
              state <= S_RD;
            end
            PH_SCAN: begin
              if (hit || idx == last) begin
                last_pick <= pk;
                if (pk > vis_lim) vis_lim <= pk;
                idx   <= pk;
                phase <= PH_PLOAD;
              end else begin
                idx <= idx + 1'b1;
              end
              state <= S_RD;
            end
            PH_SNAP: begin
              if (snap) begin
                cur_x <= rd_x;
                cur_y <= rd_y;
              end
              done     <= 1'b1;
              kind     <= KIND_GOAL;
              goal_x   <= snap ? rd_x : cur_x;
              goal_y   <= snap ? rd_y : cur_y;
              arrived  <= 1'b0;
              overflow <= over_flag;
              state    <= S_IDLE;
            end
            default: begin
              done     <= 1'b1;
              kind     <= KIND_ARRIVE;
              goal_x   <= cur_x;
              goal_y   <= cur_y;
              arrived  <= (dsum <= DIST_W'(t2));
              overflow <= over_flag;
              state    <= S_IDLE;
            end
          endcase
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) done |-> $past(state) == S_EVAL)
    else $error("result outside evaluation");
  assert property (@(posedge clk) disable iff (rst) vis_lim >= last_pick)
    else $error("visited limit below last pick");
  assert property (@(posedge clk) disable iff (rst)
    load_count <= COUNT_W'(PATH_DEPTH))
    else $error("load count past depth");
  assert property (@(posedge clk) disable iff (rst) ram_we |-> !ram_re)
    else $error("store written during a read");

endmodule
`default_nettype wire
